### sv/ifd_pkg.sv
package ifd_pkg;

	localparam logic [7:0] FRAME_HEADER = 8'h55;
	localparam logic [7:0] TYPE_TIME    = 8'h50;
	localparam logic [7:0] TYPE_ACCEL   = 8'h51;
	localparam logic [7:0] TYPE_GYRO    = 8'h52;
	localparam logic [7:0] TYPE_ANGLE   = 8'h53;

	localparam logic [3:0] POS_HUNT  = 4'd0;
	localparam logic [3:0] POS_TYPE  = 4'd1;
	localparam logic [3:0] POS_DATA0 = 4'd2;
	localparam logic [3:0] POS_CHECK = 4'd10;

	localparam logic [1:0] KIND_TIME  = 2'd0;
	localparam logic [1:0] KIND_ACCEL = 2'd1;
	localparam logic [1:0] KIND_GYRO  = 2'd2;
	localparam logic [1:0] KIND_ANGLE = 2'd3;

	localparam int VALUE_W = 20;

	// data[0] holds frame byte 2, data[7] frame byte 9
	typedef struct packed {
		logic [7:0]      ftype;
		logic [7:0][7:0] data;
	} frame_t;

	typedef struct packed {
		logic [1:0]                kind;
		logic signed [VALUE_W-1:0] x;
		logic signed [VALUE_W-1:0] y;
		logic signed [VALUE_W-1:0] z;
		logic [7:0]                minute;
		logic [7:0]                second;
		logic [15:0]               msec;
	} result_t;

	// Scale a raw word to 8 fractional bits; arithmetic shifts floor.
	function automatic logic signed [VALUE_W-1:0] scale_word(input logic [1:0] kind,
		input logic signed [15:0] w);
		logic signed [22:0]        g;
		logic signed [21:0]        a;
		logic signed [VALUE_W-1:0] r;
		g = 23'(w) * 23'sd125;
		a = 22'(w) * 22'sd45;
		unique case (kind)
			KIND_TIME:  r = '0;
			KIND_ACCEL: r = VALUE_W'(w >>> 3);
			KIND_GYRO:  r = VALUE_W'(g >>> 3);
			KIND_ANGLE: r = VALUE_W'(a >>> 5);
			default:    r = '0;
		endcase
		return r;
	endfunction

endpackage

### sv/ifd_assembler.sv
module ifd_assembler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     rx_byte,
	output ifd_pkg::frame_t frame,
	output logic           done
);
	import ifd_pkg::*;

	logic [3:0]      pos_q;
	logic [7:0]      sum_q;
	logic [7:0]      type_q;
	logic [7:0][7:0] data_q;
	logic            hunting;
	logic [2:0]      data_idx;

	assign hunting  = (pos_q == POS_HUNT) || (pos_q > POS_CHECK);
	assign data_idx = 3'(pos_q - POS_DATA0);

	// checksum byte matches the running sum of the first ten bytes
	assign done = accept && !hunting && (pos_q == POS_CHECK) && (sum_q == rx_byte);

	assign frame.ftype = type_q;
	assign frame.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			sum_q <= '0;
		end else if (accept) begin
			if (hunting) begin
				// drop anything but a header while hunting
				pos_q <= (rx_byte == FRAME_HEADER) ? POS_TYPE : POS_HUNT;
				sum_q <= rx_byte;
			end else if (pos_q < POS_CHECK) begin
				pos_q <= pos_q + 4'd1;
				sum_q <= sum_q + rx_byte;
			end else begin
				pos_q <= POS_HUNT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !hunting && pos_q < POS_CHECK) begin
			if (pos_q == POS_TYPE) begin
				type_q <= rx_byte;
			end else begin
				data_q[data_idx] <= rx_byte;
			end
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_CHECK)
		else $error("byte position out of range");

	a_check_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_q == POS_CHECK) |=> (pos_q == POS_HUNT))
		else $error("decoder did not return to hunting after checksum byte");

	a_header_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_q == POS_HUNT && rx_byte == FRAME_HEADER)
		|=> (pos_q == POS_TYPE && sum_q == FRAME_HEADER))
		else $error("header did not start a frame");
`endif

endmodule

### sv/ifd_scaler.sv
module ifd_scaler (
	input  ifd_pkg::frame_t  frame,
	output ifd_pkg::result_t res,
	output logic             known
);
	import ifd_pkg::*;

	always_comb begin
		res   = '0;
		known = 1'b1;
		unique case (frame.ftype)
			TYPE_TIME: begin
				res.kind   = KIND_TIME;
				res.minute = frame.data[4];
				res.second = frame.data[5];
				res.msec   = {frame.data[7], frame.data[6]};
			end
			TYPE_ACCEL, TYPE_GYRO, TYPE_ANGLE: begin
				res.kind = frame.ftype[1:0];
				res.x    = scale_word(frame.ftype[1:0], {frame.data[1], frame.data[0]});
				res.y    = scale_word(frame.ftype[1:0], {frame.data[3], frame.data[2]});
				res.z    = scale_word(frame.ftype[1:0], {frame.data[5], frame.data[4]});
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

endmodule

### sv/ifd_out_queue.sv
module ifd_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  ifd_pkg::result_t wdata,
	output logic             full,
	output logic             out_valid,
	input  logic             out_ready,
	output ifd_pkg::result_t rdata
);
	import ifd_pkg::*;

	localparam logic [1:0] QUEUE_FULL = 2'd2;

	result_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       rd;

	assign full      = (count_q == QUEUE_FULL);
	assign out_valid = (count_q != 2'd0);
	assign rd        = out_valid && out_ready;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr && !rd) begin
				count_q <= count_q + 2'd1;
			end else if (rd && !wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr)
		else $error("result written into a full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_FULL)
		else $error("queue count out of range");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> (count_q == $past(count_q) + 2'd1))
		else $error("queue count did not advance on write");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(rd && !wr) |=> (count_q == $past(count_q) - 2'd1))
		else $error("queue count did not drop on read");
`endif

endmodule

### sv/imu_frame_decoder_top.sv
// Sensor frame decoder.
// Input channel (in_valid/in_ready, rx_byte): one received serial byte per
// request. The decoder hunts for the 0x55 header, collects the type byte,
// eight data bytes and the checksum byte, and checks the checksum against
// the 8-bit sum of the first ten bytes.
// Output channel (out_valid/out_ready): one result per good frame of a known
// type: a time stamp (minute, second, milliseconds) or three scaled axis
// values with 8 fractional bits (acceleration, angular rate or angle).
// Bad checksums and unknown types give no result.
// Throughput: one byte per cycle while in_ready is high. A result is
// queued as its checksum byte is taken; the scaling is a single pass of
// logic between the frame byte registers and a two-entry result queue.
// Stalls: while the receiver holds out_ready low, results wait in the queue;
// in_ready drops only when both entries are occupied.
// Reset: the decoder hunts for a header and the result queue is empty.
module imu_frame_decoder_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         rx_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         frame_kind,
	output logic signed [ifd_pkg::VALUE_W-1:0] value_x,
	output logic signed [ifd_pkg::VALUE_W-1:0] value_y,
	output logic signed [ifd_pkg::VALUE_W-1:0] value_z,
	output logic [7:0]                         minute_val,
	output logic [7:0]                         second_val,
	output logic [15:0]                        millisecond_val
);
	import ifd_pkg::*;

	logic    accept;
	logic    done;
	logic    known;
	logic    full;
	frame_t  frame;
	result_t res;
	result_t rdata;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	ifd_assembler u_assembler (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.frame   (frame),
		.done    (done)
	);

	ifd_scaler u_scaler (
		.frame (frame),
		.res   (res),
		.known (known)
	);

	ifd_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (done && known),
		.wdata     (res),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rdata     (rdata)
	);

	assign frame_kind      = rdata.kind;
	assign value_x         = rdata.x;
	assign value_y         = rdata.y;
	assign value_z         = rdata.z;
	assign minute_val      = rdata.minute;
	assign second_val      = rdata.second;
	assign millisecond_val = rdata.msec;

endmodule

### tb/imu_frame_checker.sv
module imu_frame_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [7:0]                         rx_byte,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [1:0]                         frame_kind,
	input  logic signed [ifd_pkg::VALUE_W-1:0] value_x,
	input  logic signed [ifd_pkg::VALUE_W-1:0] value_y,
	input  logic signed [ifd_pkg::VALUE_W-1:0] value_z,
	input  logic [7:0]                         minute_val,
	input  logic [7:0]                         second_val,
	input  logic [15:0]                        millisecond_val,
	output int                                 fail_count,
	output int                                 waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	import ifd_pkg::*;

	result_t    decoded_q[$];
	logic [7:0] frame_buf [10];
	logic [3:0] frame_pos;
	logic [7:0] frame_sum;
	int         mismatches = 0;

	initial begin
		fail_count = 0;
		waiting    = 0;
	end

	// Scale to 8 fractional bits; >>> on a signed int floors
	function automatic logic signed [VALUE_W-1:0] scale_axis(input logic [1:0] kind,
		input logic [15:0] raw);
		int w;
		int v;
		w = $signed(raw);
		case (kind)
			KIND_ACCEL: v = w >>> 3;
			KIND_GYRO:  v = (w * 125) >>> 3;
			default:    v = (w * 45) >>> 5;
		endcase
		return VALUE_W'(v);
	endfunction

	task decode_rx_byte(input logic [7:0] b);
		result_t    r;
		logic [7:0] ftype;
		if (frame_pos == POS_HUNT || frame_pos > POS_CHECK) begin
			// drop everything but a header while hunting
			if (b == FRAME_HEADER) begin
				frame_buf[0] = b;
				frame_sum    = b;
				frame_pos    = POS_TYPE;
			end else begin
				frame_pos = POS_HUNT;
			end
		end else if (frame_pos < POS_CHECK) begin
			frame_buf[frame_pos] = b;
			frame_sum            = frame_sum + b;
			frame_pos            = frame_pos + 4'd1;
		end else begin
			frame_pos = POS_HUNT;
			if (frame_sum == b) begin
				ftype = frame_buf[1];
				r     = '0;
				if (ftype == TYPE_TIME) begin
					r.kind   = KIND_TIME;
					r.minute = frame_buf[6];
					r.second = frame_buf[7];
					r.msec   = {frame_buf[9], frame_buf[8]};
					decoded_q.push_back(r);
				end else if (ftype >= TYPE_ACCEL && ftype <= TYPE_ANGLE) begin
					case (ftype)
						TYPE_ACCEL: r.kind = KIND_ACCEL;
						TYPE_GYRO:  r.kind = KIND_GYRO;
						default:    r.kind = KIND_ANGLE;
					endcase
					r.x = scale_axis(r.kind, {frame_buf[3], frame_buf[2]});
					r.y = scale_axis(r.kind, {frame_buf[5], frame_buf[4]});
					r.z = scale_axis(r.kind, {frame_buf[7], frame_buf[6]});
					decoded_q.push_back(r);
				end
			end
		end
	endtask

	task log_failure(input string what, input result_t want, input result_t got);
		if (mismatches < 10) begin
			$write("%0t %s: want kind %0d x %0d y %0d z %0d min %0d sec %0d ms %0d",
				$time, what, want.kind, want.x, want.y, want.z, want.minute,
				want.second, want.msec);
			$display(" | got kind %0d x %0d y %0d z %0d min %0d sec %0d ms %0d",
				got.kind, got.x, got.y, got.z, got.minute, got.second, got.msec);
		end
		mismatches++;
		fail_count = mismatches;
	endtask

	task check_result();
		result_t got;
		result_t want;
		got.kind   = frame_kind;
		got.x      = value_x;
		got.y      = value_y;
		got.z      = value_z;
		got.minute = minute_val;
		got.second = second_val;
		got.msec   = millisecond_val;
		if (decoded_q.size() == 0) begin
			log_failure("unexpected result", '0, got);
		end else begin
			want = decoded_q.pop_front();
			if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
				got.z !== want.z || got.minute !== want.minute ||
				got.second !== want.second || got.msec !== want.msec)
				log_failure("result mismatch", want, got);
		end
	endtask

	// Sample between edges: everything is settled for the coming rising edge
	always @(negedge clk) begin
		if (!arst_n) begin
			decoded_q.delete();
			for (int i = 0; i < 10; i++)
				frame_buf[i] = '0;
			frame_pos = POS_HUNT;
			frame_sum = '0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				decode_rx_byte(rx_byte);
		end
		waiting = decoded_q.size();
	end

endmodule

### tb/tb_imu_frame_decoder_top.sv
module tb_imu_frame_decoder_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ifd_pkg::*;

	localparam logic [7:0] TYPE_BELOW = TYPE_TIME - 8'd1;
	localparam logic [7:0] TYPE_ABOVE = TYPE_ANGLE + 8'd1;
	localparam int         BYTE_TARGET = 550;
	localparam int         HOLD_CYCLES = 300;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [7:0]                  rx_byte = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [1:0]                  frame_kind;
	logic signed [VALUE_W-1:0]   value_x;
	logic signed [VALUE_W-1:0]   value_y;
	logic signed [VALUE_W-1:0]   value_z;
	logic [7:0]                  minute_val;
	logic [7:0]                  second_val;
	logic [15:0]                 millisecond_val;

	int fails;
	int waiting;
	int frame_bytes_sent = 0;
	bit hold_req = 1'b0;
	bit no_gaps = 1'b0;

	imu_frame_decoder_top uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_kind      (frame_kind),
		.value_x         (value_x),
		.value_y         (value_y),
		.value_z         (value_z),
		.minute_val      (minute_val),
		.second_val      (second_val),
		.millisecond_val (millisecond_val)
	);

	imu_frame_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_kind      (frame_kind),
		.value_x         (value_x),
		.value_y         (value_y),
		.value_z         (value_z),
		.minute_val      (minute_val),
		.second_val      (second_val),
		.millisecond_val (millisecond_val),
		.fail_count      (fails),
		.waiting         (waiting)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side: mostly ready, short and occasional long stalls, one long hold
	initial begin
		int r;
		int len;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_ready <= 1'b1;
					len = $urandom_range(1, 20);
				end else if (r < 94) begin
					out_ready <= 1'b0;
					len = $urandom_range(1, 3);
				end else begin
					out_ready <= 1'b0;
					len = $urandom_range(10, 40);
				end
				repeat (len) @(posedge clk);
			end
		end
	end

	// Offer one byte; returns at the edge where the request is taken
	task automatic send_byte(input logic [7:0] b);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 65)
			gap = 0;
		else if (r < 95)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		frame_bytes_sent++;
	endtask

	// payload[7:0] is frame byte 2; count below 11 cuts the frame short
	task automatic send_frame(input logic [7:0] ftype, input logic [63:0] payload,
		input logic [7:0] sum_flip, input int count);
		logic [7:0] fb [11];
		logic [7:0] s;
		fb[0] = FRAME_HEADER;
		fb[1] = ftype;
		for (int i = 0; i < 8; i++)
			fb[2 + i] = payload[8 * i +: 8];
		s = '0;
		for (int i = 0; i < 10; i++)
			s = s + fb[i];
		fb[10] = s ^ sum_flip;
		for (int i = 0; i < count; i++)
			send_byte(fb[i]);
	endtask

	function automatic logic [15:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return 16'h8000;
		else if (r < 12)
			return 16'h7FFF;
		else if (r < 16)
			return 16'hFFFF;
		else if (r < 20)
			return 16'h0000;
		return 16'($urandom);
	endfunction

	task automatic send_random_frame(input bit clean, input int count);
		logic [7:0]  ftype;
		logic [63:0] payload;
		logic [7:0]  flip;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 90)
			ftype = TYPE_TIME + 8'($urandom_range(0, 3));
		else
			ftype = 8'($urandom_range(0, 255));
		payload = {16'($urandom), pick_word(), pick_word(), pick_word()};
		// a header byte inside the data must not restart the frame
		if ($urandom_range(0, 9) == 0)
			payload[8 * $urandom_range(0, 7) +: 8] = FRAME_HEADER;
		flip = '0;
		if (!clean && $urandom_range(0, 9) == 0)
			flip = 8'($urandom_range(1, 255));
		send_frame(ftype, payload, flip, count);
	endtask

	// Hold the sender until every predicted result has been delivered
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	initial begin
		int  r;
		bit  squeezed;
		bit  paused;
		squeezed = 1'b0;
		paused   = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of every kind: min, max and minus one per axis (minus seven for angle z)
		send_frame(TYPE_TIME, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 11);
		send_frame(TYPE_TIME, 64'h0000_0000_0000_0000, 8'h00, 11);
		send_frame(TYPE_ACCEL, 64'h1234_FFFF_7FFF_8000, 8'h00, 11);
		send_frame(TYPE_GYRO, 64'hA5A5_FFFF_7FFF_8000, 8'h00, 11);
		send_frame(TYPE_ANGLE, 64'h5A5A_FFF9_7FFF_8000, 8'h00, 11);
		// bad checksum, then unknown types with a good checksum
		send_frame(TYPE_ACCEL, 64'h0102_0304_0506_0708, 8'h01, 11);
		send_frame(TYPE_ABOVE, 64'h1111_2222_3333_4444, 8'h00, 11);
		send_frame(TYPE_BELOW, 64'h5555_6666_7777_8888, 8'h00, 11);
		// cut-short frame swallows the header of the next one
		send_frame(TYPE_GYRO, 64'h0000_0000_0001_FFFF, 8'h00, 5);
		send_frame(TYPE_GYRO, 64'h0000_0000_0001_FFFF, 8'h00, 11);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(TYPE_ANGLE, 64'h0000_0001_FFFF_0000, 8'h00, 11);
		drain();

		while (frame_bytes_sent < BYTE_TARGET) begin
			if (!squeezed && frame_bytes_sent >= 250) begin
				// stall the results and keep pushing so the input backs up
				squeezed = 1'b1;
				hold_req = 1'b1;
				no_gaps  = 1'b1;
				repeat (4) send_random_frame(1'b1, 11);
				no_gaps  = 1'b0;
			end
			if (!paused && frame_bytes_sent >= 400) begin
				paused = 1'b1;
				drain();
			end
			r = $urandom_range(0, 99);
			if (r % 4 == 0)
				no_gaps = 1'b1;
			if (r < 75) begin
				send_random_frame(1'b0, 11);
			end else if (r < 85) begin
				send_random_frame(1'b0, $urandom_range(2, 10));
			end else begin
				repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
			end
			no_gaps = 1'b0;
		end

		drain();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
sv/ifd_pkg.sv
sv/ifd_assembler.sv
sv/ifd_scaler.sv
sv/ifd_out_queue.sv
sv/imu_frame_decoder_top.sv
tb/imu_frame_checker.sv
tb/tb_imu_frame_decoder_top.sv
